// ===== hw/rtl/bhpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bhpc_pkg
// shared widths, field offsets, types and helpers of the pose compose unit
// ----------------------------------------------------------------------------
package bhpc_pkg;

    localparam int MAX_BONES_DEF = 64;

    localparam int ELEM_W   = 32;
    localparam int LANES    = 4;
    localparam int ROW_W    = ELEM_W * LANES;
    localparam int BONE_W   = 8;
    localparam int PARENT_W = 9;
    localparam int RNUM_W   = 2;
    localparam int COUNT_W  = 9;
    localparam int Q_FRAC   = 16;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd64;
    localparam logic [ELEM_W-1:0]  Q_ONE       = 32'h0001_0000;

    // step and row codes
    localparam logic [RNUM_W-1:0] FIRST_K  = 2'd0;
    localparam logic [RNUM_W-1:0] LAST_K   = 2'd3;
    localparam logic [RNUM_W-1:0] ROW_LAST = 2'd3;

    // input tdata layout
    localparam int S_BONE_LSB   = 0;
    localparam int S_PARENT_LSB = S_BONE_LSB + BONE_W;
    localparam int S_ROW_LSB    = S_PARENT_LSB + PARENT_W;
    localparam int S_LOC_LSB    = S_ROW_LSB + RNUM_W;
    localparam int S_FIELDS_W   = S_LOC_LSB + ROW_W;
    localparam int S_TDATA_W    = ((S_FIELDS_W + 7) / 8) * 8;

    // output tdata layout
    localparam int M_BONE_LSB = 0;
    localparam int M_ROW_LSB  = M_BONE_LSB + BONE_W;
    localparam int M_ELEM_LSB = M_ROW_LSB + RNUM_W;
    localparam int M_FIELDS_W = M_ELEM_LSB + ROW_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    typedef logic [LANES-1:0][ELEM_W-1:0] row_t;

    typedef struct packed {
        logic              valid;
        logic [RNUM_W-1:0] k;
        logic [BONE_W-1:0] bone;
        logic [RNUM_W-1:0] row;
    } mac_ctl_t;

    function automatic row_t ident_row(input logic [RNUM_W-1:0] k);
        row_t r;
        r    = '0;
        r[k] = Q_ONE;
        return r;
    endfunction

endpackage

// ===== hw/rtl/bone_hierarchy_pose_compose_unit.sv =====
// pipeline: issue stage, memory stage, multiply register, output buffer; four issue steps per item,
//   one parent-row read each for a non-root item, and the next item is taken as the last step issues
// a non-root item whose parent has a row-3 item in the pipe or a commit in flight waits before its
//   first parent-row read until the four row writes of that commit are done
// reset: synchronous active-low aresetn clears control state, pending rows and bone valid bits,
//   bone_count returns to 64; no clearing pass, a bone never written reads as identity
// ----------------------------------------------------------------------------
// bone_hierarchy_pose_compose_unit
// forward kinematics on 4x4 Q16.16 matrices: local row times parent model matrix
// ----------------------------------------------------------------------------
module bone_hierarchy_pose_compose_unit #(
    parameter int MAX_BONES = bhpc_pkg::MAX_BONES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // bone_count register write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bhpc_pkg::COUNT_W-1:0]      cfg_data,
    // input rows
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // bone_index, parent_index, row_number, local_e0, local_e1, local_e2, local_e3, zero pad
    input  logic [bhpc_pkg::S_TDATA_W-1:0]    s_tdata,
    // result rows
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_bone, out_row, model_e0, model_e1, model_e2, model_e3, zero pad
    output logic [bhpc_pkg::M_TDATA_W-1:0]    m_tdata
);
    import bhpc_pkg::*;

    localparam int POSE_DEPTH = MAX_BONES * LANES;
    localparam int ADDR_W     = $clog2(POSE_DEPTH);
    localparam int BONE_IW    = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_BONES);
    localparam logic [1:0] OUT_FULL = 2'd2;
    localparam logic [1:0] OUT_ONE  = 2'd1;
    localparam logic [1:0] OUT_NONE = 2'd0;

    // configuration
    logic [COUNT_W-1:0] bone_count_reg;
    logic [COUNT_W-1:0] count_eff;

    // issue stage: holds one item over its four steps, reading its four parent rows if not a root
    logic                iss_valid_reg;
    logic [RNUM_W-1:0]   iss_k_reg;
    logic [BONE_W-1:0]   iss_bone_reg;
    logic [PARENT_W-1:0] iss_parent_reg;
    logic [RNUM_W-1:0]   iss_row_reg;
    row_t                iss_loc_reg;
    logic [BONE_W-1:0]   iss_pidx;
    logic                iss_root;
    logic                hazard;
    logic                iss_go;
    logic                iss_end;
    logic                s_accept;

    // memory stage
    mac_ctl_t            m_ctl_reg;
    logic [ELEM_W-1:0]   m_loc_reg;
    logic                m_ident_reg;
    row_t                rd_data_reg;
    row_t                mac_row;

    // pose memory, one matrix row per entry
    row_t                pose_mem [POSE_DEPTH];
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [MAX_BONES-1:0] bone_vld_reg;

    // multiply / accumulate
    mac_ctl_t            x_ctl;
    row_t                x_sum;
    logic                x_done;
    logic                adv;
    logic                fin;

    // pending rows and commit sequencer
    row_t                pending_reg [LANES];
    logic                cmt_start;
    logic                cmt_active_reg;
    logic [RNUM_W-1:0]   cmt_k_reg;
    logic [BONE_W-1:0]   cmt_bone_reg;

    // two-entry output buffer
    logic [1:0]            out_count_reg;
    logic [M_FIELDS_W-1:0] out_head_reg;
    logic [M_FIELDS_W-1:0] out_tail_reg;
    logic [M_FIELDS_W-1:0] out_new;
    logic                  pop;

    // ---------------------------------------------------------------- config
    assign cfg_ready = 1'b1;
    assign count_eff = (bone_count_reg > MAX_COUNT) ? MAX_COUNT : bone_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bone_count_reg <= COUNT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            bone_count_reg <= cfg_data;
        end
    end

    // ---------------------------------------------------------------- issue
    assign iss_pidx = iss_parent_reg[BONE_W-1:0];
    // negative parent or parent at or above the count in force is a root
    assign iss_root = iss_parent_reg[PARENT_W-1] || ({1'b0, iss_pidx} >= count_eff);

    // parent must be read as last committed: before the first row read, wait for any
    // earlier row-3 item of that bone still in the pipe or being written back
    assign hazard = !iss_root && (iss_k_reg == FIRST_K) &&
                    ((m_ctl_reg.valid && m_ctl_reg.row == ROW_LAST &&
                      m_ctl_reg.bone == iss_pidx) ||
                     (x_ctl.valid && x_ctl.row == ROW_LAST && x_ctl.bone == iss_pidx) ||
                     (cmt_active_reg && cmt_bone_reg == iss_pidx));

    // whole pipe freezes only when a finished row finds the output buffer full
    assign x_done   = x_ctl.valid && x_ctl.k == LAST_K;
    assign adv      = !(x_done && out_count_reg == OUT_FULL);
    assign iss_go   = adv && iss_valid_reg && !hazard;
    assign iss_end  = iss_go && iss_k_reg == LAST_K;
    assign s_tready = !iss_valid_reg || iss_end;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iss_valid_reg <= 1'b0;
            iss_k_reg     <= FIRST_K;
        end else begin
            if (s_accept) begin
                iss_valid_reg <= 1'b1;
                iss_k_reg     <= FIRST_K;
            end else if (iss_end) begin
                iss_valid_reg <= 1'b0;
            end else if (iss_go) begin
                iss_k_reg <= iss_k_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            iss_bone_reg   <= s_tdata[S_BONE_LSB +: BONE_W];
            iss_parent_reg <= s_tdata[S_PARENT_LSB +: PARENT_W];
            iss_row_reg    <= s_tdata[S_ROW_LSB +: RNUM_W];
            iss_loc_reg    <= s_tdata[S_LOC_LSB +: ROW_W];
        end
    end

    // ---------------------------------------------------------------- pose memory
    assign rd_en   = iss_go && !iss_root;
    assign rd_addr = ADDR_W'({iss_pidx, iss_k_reg});
    assign wr_en   = cmt_active_reg;
    assign wr_addr = ADDR_W'({cmt_bone_reg, cmt_k_reg});

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pose_mem[wr_addr] <= pending_reg[cmt_k_reg];
        end
        if (rd_en) begin
            rd_data_reg <= pose_mem[rd_addr];
        end
    end

    // ---------------------------------------------------------------- memory stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_ctl_reg.valid <= 1'b0;
        end else begin
            if (adv) begin
                m_ctl_reg.valid <= iss_go;
            end
            if (iss_go) begin
                m_ctl_reg.k    <= iss_k_reg;
                m_ctl_reg.bone <= iss_bone_reg;
                m_ctl_reg.row  <= iss_row_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (iss_go) begin
            m_loc_reg      <= iss_loc_reg[iss_k_reg];
            // root or never-written parent behaves as identity, giving the local row back
            m_ident_reg    <= iss_root || !bone_vld_reg[iss_pidx[BONE_IW-1:0]];
        end
    end

    assign mac_row = m_ident_reg ? ident_row(m_ctl_reg.k) : rd_data_reg;

    bhpc_row_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in_ctl  (m_ctl_reg),
        .in_loc  (m_loc_reg),
        .in_row  (mac_row),
        .x_ctl   (x_ctl),
        .x_sum   (x_sum)
    );

    // ---------------------------------------------------------------- pending rows and commit
    assign fin       = adv && x_done;
    // bones beyond the store still give their row but never commit
    assign cmt_start = fin && x_ctl.row == ROW_LAST && ({1'b0, x_ctl.bone} < MAX_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < LANES; r++) begin
                pending_reg[r] <= '0;
            end
            cmt_active_reg <= 1'b0;
            cmt_k_reg      <= FIRST_K;
            bone_vld_reg   <= '0;
        end else begin
            if (fin) begin
                pending_reg[x_ctl.row] <= x_sum;
            end
            // last row write of a commit marks the bone as holding real data
            if (cmt_active_reg && cmt_k_reg == LAST_K) begin
                bone_vld_reg[cmt_bone_reg[BONE_IW-1:0]] <= 1'b1;
            end
            if (cmt_start) begin
                cmt_active_reg <= 1'b1;
                cmt_k_reg      <= FIRST_K;
            end else if (cmt_active_reg) begin
                if (cmt_k_reg == LAST_K) begin
                    cmt_active_reg <= 1'b0;
                end
                cmt_k_reg <= cmt_k_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmt_start) begin
            cmt_bone_reg <= x_ctl.bone;
        end
    end

    // ---------------------------------------------------------------- output buffer
    assign out_new  = {x_sum, x_ctl.row, x_ctl.bone};
    assign m_tvalid = out_count_reg != OUT_NONE;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_head_reg};
    assign pop      = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_count_reg <= OUT_NONE;
        end else if (fin && !pop) begin
            out_count_reg <= out_count_reg + 1'b1;
        end else if (!fin && pop) begin
            out_count_reg <= out_count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            if (fin && out_count_reg == OUT_ONE) begin
                out_head_reg <= out_new;
            end else if (out_count_reg == OUT_FULL) begin
                out_head_reg <= out_tail_reg;
                if (fin) begin
                    out_tail_reg <= out_new;
                end
            end
        end else if (fin) begin
            if (out_count_reg == OUT_NONE) begin
                out_head_reg <= out_new;
            end else begin
                out_tail_reg <= out_new;
            end
        end
    end

`ifndef SYNTHESIS
    // never read a bone whose commit is still being written
    a_no_read_during_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_en && cmt_active_reg) |-> (iss_pidx != cmt_bone_reg))
        else $error("parent row read while its commit is in flight");

    // output buffer never overflows
    a_out_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (fin && !pop) |-> (out_count_reg != OUT_FULL))
        else $error("result pushed into a full output buffer");

    // commits never overlap except at the final row write
    a_commit_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        cmt_start |-> (!cmt_active_reg || cmt_k_reg == LAST_K))
        else $error("commit started over an unfinished commit");

    // a finished commit leaves its bone marked valid
    a_commit_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmt_active_reg && cmt_k_reg == LAST_K) |=>
            bone_vld_reg[$past(cmt_bone_reg[BONE_IW-1:0])])
        else $error("committed bone not marked valid");
`endif

endmodule

// ===== hw/rtl/bhpc_row_mac.sv =====
// ----------------------------------------------------------------------------
// bhpc_row_mac
// four-lane multiply stage and accumulator for one result row
// ----------------------------------------------------------------------------
module bhpc_row_mac (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                adv,
    input  bhpc_pkg::mac_ctl_t                  in_ctl,
    input  logic signed [bhpc_pkg::ELEM_W-1:0]  in_loc,
    input  bhpc_pkg::row_t                      in_row,
    output bhpc_pkg::mac_ctl_t                  x_ctl,
    output bhpc_pkg::row_t                      x_sum
);
    import bhpc_pkg::*;

    logic                       x_valid_reg;
    mac_ctl_t                   x_info_reg;
    row_t                       prod_reg;
    row_t                       acc_reg;
    row_t                       base;
    logic signed [2*ELEM_W-1:0] prod_full [LANES];

    // one 32x32 product per lane, truncated back to Q16.16 by dropping 16 fraction and 16 top bits
    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            prod_full[j] = in_loc * $signed(in_row[j]);
        end
    end

    always_comb begin
        base = (x_info_reg.k == FIRST_K) ? '0 : acc_reg;
        for (int j = 0; j < LANES; j++) begin
            x_sum[j] = base[j] + prod_reg[j];
        end
    end

    always_comb begin
        x_ctl       = x_info_reg;
        x_ctl.valid = x_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_valid_reg <= 1'b0;
        end else if (adv) begin
            x_valid_reg <= in_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && in_ctl.valid) begin
            x_info_reg <= in_ctl;
            for (int j = 0; j < LANES; j++) begin
                prod_reg[j] <= prod_full[j][Q_FRAC +: ELEM_W];
            end
        end
        if (adv && x_valid_reg) begin
            acc_reg <= x_sum;
        end
    end

endmodule
